// File: rtl/sbsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_START   = 56;
   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned HASH_WORDS  = 5;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_ABSORB = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // index 0 is H0
   localparam logic [4:0][31:0] INIT_HASH = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [3:0][31:0] ROUND_K = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         init;       // load initial hash, clear length and count
      logic         shift;      // shift one byte into the block buffer
      byte_sel_type byte_sel;
      logic         count_len;  // add 8 to the bit length
      logic         load_work;  // a..e <= hash
      logic         round;      // one compression round
      logic [1:0]   round_grp;  // t / 20
      logic         add_hash;   // hash += a..e
      logic [2:0]   word_sel;   // digest word on the result port
   } cmd_type;

   typedef struct packed {
      logic full_next;  // byte count is 63
      logic at_len;     // byte count is 56
   } status_type;

endpackage

`default_nettype wire

// File: rtl/sbsh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sbsh_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sbsh_pkg::cmd_type cmd,
   input  wire logic [7:0]        data_byte,
   output sbsh_pkg::status_type   status,
   output logic [31:0]            digest_word
);

   logic [511:0]      blk_ff, blk_in;
   logic [4:0][31:0]  hash_ff, hash_in;
   logic [4:0][31:0]  work_ff, work_in;
   logic [63:0]       len_ff, len_in;
   logic [5:0]        count_ff, count_in;

   logic [7:0]  byte_val;
   logic [7:0]  len_byte;
   logic [31:0] w0, w2, w8, w13, w_next, x;
   logic [31:0] a, b, c, d, e, f, tmp;

   // word j of the block sits at blk_ff[511-32j -: 32]
   assign w0  = blk_ff[511:480];
   assign w2  = blk_ff[447:416];
   assign w8  = blk_ff[255:224];
   assign w13 = blk_ff[95:64];
   assign x      = w13 ^ w8 ^ w2 ^ w0;
   assign w_next = {x[30:0], x[31]};

   assign len_byte = 8'(len_ff >> {~count_ff[2:0], 3'b000});

   always_comb begin
      case (cmd.byte_sel)
         sbsh_pkg::SEL_DATA: byte_val = data_byte;
         sbsh_pkg::SEL_PAD:  byte_val = sbsh_pkg::PAD_BYTE;
         sbsh_pkg::SEL_ZERO: byte_val = 8'h00;
         sbsh_pkg::SEL_LEN:  byte_val = len_byte;
         default:            byte_val = 8'h00;
      endcase
   end

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   always_comb begin
      case (cmd.round_grp)
         2'd0:    f = (b & c) | (~b & d);
         2'd2:    f = (b & c) | (b & d) | (c & d);
         default: f = b ^ c ^ d;
      endcase
   end

   assign tmp = {a[26:0], a[31:27]} + f + e + w0 + sbsh_pkg::ROUND_K[cmd.round_grp];

   always_comb begin
      blk_in   = blk_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;
      len_in   = len_ff;
      count_in = count_ff;
      if (cmd.shift) begin
         blk_in   = {blk_ff[503:0], byte_val};
         count_in = count_ff + 6'd1;
      end
      if (cmd.count_len) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.round) begin
         blk_in     = {blk_ff[479:0], w_next};
         work_in[4] = d;
         work_in[3] = c;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[1] = a;
         work_in[0] = tmp;
      end
      if (cmd.add_hash) begin
         for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.init) begin
         hash_in  = sbsh_pkg::INIT_HASH;
         len_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
      if (reset) begin
         hash_ff  <= sbsh_pkg::INIT_HASH;
         len_ff   <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   assign status.full_next = (count_ff == 6'(sbsh_pkg::BLOCK_BYTES - 1));
   assign status.at_len    = (count_ff == 6'(sbsh_pkg::LEN_START));

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         default: digest_word = hash_ff[4];
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/sbsh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sbsh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_op,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_digest_last,
   input  wire sbsh_pkg::status_type status,
   output sbsh_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type  state_ff, ret_ff;
   logic [6:0] round_ff;
   logic [2:0] idx_ff;

   logic req_xfer, rsp_xfer, last_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign last_word = (idx_ff == 3'(sbsh_pkg::HASH_WORDS - 1));
   assign rsp_digest_last = last_word;

   always_comb begin
      cmd = '0;
      cmd.byte_sel = sbsh_pkg::SEL_ZERO;
      cmd.word_sel = idx_ff;
      if (round_ff < 7'd20) begin
         cmd.round_grp = 2'd0;
      end else if (round_ff < 7'd40) begin
         cmd.round_grp = 2'd1;
      end else if (round_ff < 7'd60) begin
         cmd.round_grp = 2'd2;
      end else begin
         cmd.round_grp = 2'd3;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_op)
                  sbsh_pkg::OP_START: cmd.init = 1'b1;
                  sbsh_pkg::OP_ABSORB: begin
                     cmd.shift     = 1'b1;
                     cmd.byte_sel  = sbsh_pkg::SEL_DATA;
                     cmd.count_len = 1'b1;
                  end
                  sbsh_pkg::OP_FINISH: begin
                     cmd.shift    = 1'b1;
                     cmd.byte_sel = sbsh_pkg::SEL_PAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_PAD: begin
            if (!status.at_len) begin
               cmd.shift = 1'b1;
            end
         end
         ST_LEN: begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = sbsh_pkg::SEL_LEN;
         end
         ST_LOAD:  cmd.load_work = 1'b1;
         ST_ROUND: cmd.round     = 1'b1;
         ST_ADD:   cmd.add_hash  = 1'b1;
         ST_OUT: begin
            if (rsp_xfer && last_word) begin
               cmd.init = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_op == sbsh_pkg::OP_ABSORB && status.full_next) begin
                     state_ff <= ST_LOAD;
                     ret_ff   <= ST_IDLE;
                  end else if (req_op == sbsh_pkg::OP_FINISH) begin
                     state_ff <= status.full_next ? ST_LOAD : ST_PAD;
                     ret_ff   <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               if (status.at_len) begin
                  state_ff <= ST_LEN;
               end else if (status.full_next) begin
                  state_ff <= ST_LOAD;
                  ret_ff   <= ST_PAD;
               end
            end
            ST_LEN: begin
               if (status.full_next) begin
                  state_ff <= ST_LOAD;
                  ret_ff   <= ST_OUT;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_ROUND;
               round_ff <= '0;
            end
            ST_ROUND: begin
               round_ff <= round_ff + 7'd1;
               if (round_ff == 7'(sbsh_pkg::ROUNDS - 1)) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: state_ff <= ret_ff;
            ST_OUT: begin
               if (rsp_xfer) begin
                  if (last_word) begin
                     idx_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-1 hasher fed one byte per transfer. op start resets the message, absorb appends
// req_data_byte, finish pads the message and returns the five digest words H0..H4 on
// the rsp channel, the fifth marked by rsp_digest_last; afterwards the block is back in
// the start state. Start and absorb complete in the cycle of their transfer, except that
// the 64th byte of a block triggers a compression (load, 80 rounds through the single
// round unit, hash update) during which input is held off. Finish shifts padding and
// length into the block buffer byte by byte and compresses one or two blocks before the
// first digest word is offered, then one transfer per word. Input is held off from
// finish until the last word leaves. The block buffer doubles as the rolling message
// schedule during compression.
module sha1_byte_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_digest_last
);

   sbsh_pkg::cmd_type    cmd;
   sbsh_pkg::status_type status;

   sbsh_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_last (rsp_digest_last),
      .status          (status),
      .cmd             (cmd)
   );

   sbsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire
